// File: hdl/adc_voltmeter_display_dimmer_defines.svh
// ----------------------------------------------------------------------------
// adc voltmeter display dimmer - assertion macros
// shared concurrent assertion forms, clocked on the rising edge, async reset
// ----------------------------------------------------------------------------
`ifndef ADC_VOLTMETER_DISPLAY_DIMMER_DEFINES_SVH
`define ADC_VOLTMETER_DISPLAY_DIMMER_DEFINES_SVH

// same-cycle implication
`define AVD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AVD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/avd_pkg.sv
// ----------------------------------------------------------------------------
// avd_pkg
// shared widths, codes, constants, types and the segment decoder
// ----------------------------------------------------------------------------
package avd_pkg;

	localparam int unsigned AVD_BATCH_SAMPLES = 8;

	localparam int unsigned AVD_SAMPLE_W  = 10;
	localparam int unsigned AVD_MODE_W    = 2;
	localparam int unsigned AVD_SEG_W     = 7;
	localparam int unsigned AVD_BCD_W     = 6;
	localparam int unsigned AVD_VOLT_W    = 6;
	localparam int unsigned AVD_PERIOD_W  = 16;
	localparam int unsigned AVD_CMP_W     = 17;
	localparam int unsigned AVD_DUTY_W    = 8;

	localparam int unsigned AVD_SAMPLE_MAX = 1023;
	// 33 / 1023 reduces to 1 / 31
	localparam int unsigned AVD_VOLT_DIV   = 31;

	localparam logic [AVD_PERIOD_W-1:0] AVD_PERIOD_RESET = 16'd49999;

	localparam logic       AVD_CMD_SAMPLE = 1'b0;
	localparam logic       AVD_CMD_TICK   = 1'b1;
	localparam logic [1:0] AVD_MODE_OFF    = 2'd0;
	localparam logic [1:0] AVD_MODE_FREEZE = 2'd1;

	localparam int unsigned AVD_DUTY_FULL     = 100;
	localparam int unsigned AVD_DUTY_FALLBACK = 50;

	// exact x / 100 for x < 2^23 by multiply and shift
	localparam int unsigned AVD_PCT         = 100;
	localparam int unsigned AVD_PCT_SHIFT   = 30;
	localparam int unsigned AVD_PCT_RECIP_W = 24;
	localparam logic [AVD_PCT_RECIP_W-1:0] AVD_PCT_RECIP =
		AVD_PCT_RECIP_W'((2 ** AVD_PCT_SHIFT + AVD_PCT - 1) / AVD_PCT);

	typedef struct packed {
		logic                    we;
		logic [AVD_PERIOD_W-1:0] data;
	} avd_cfg_t;

	typedef struct packed {
		logic [AVD_SEG_W-1:0]  seg;
		logic                  high;
		logic                  disp;
		logic                  done;
		logic [AVD_MODE_W-1:0] mode;
		logic [AVD_BCD_W-1:0]  bcd;
	} avd_mid_t;

	function automatic logic [AVD_SEG_W-1:0] avd_seg7(input logic [3:0] d);
		logic [AVD_SEG_W-1:0] s;
		case (d)
			4'h0: s = 7'h3F;
			4'h1: s = 7'h06;
			4'h2: s = 7'h5B;
			4'h3: s = 7'h4F;
			4'h4: s = 7'h66;
			4'h5: s = 7'h6D;
			4'h6: s = 7'h7D;
			4'h7: s = 7'h07;
			4'h8: s = 7'h7F;
			4'h9: s = 7'h6F;
			4'hA: s = 7'h77;
			4'hB: s = 7'h7C;
			4'hC: s = 7'h39;
			4'hD: s = 7'h5E;
			4'hE: s = 7'h79;
			default: s = 7'h71;
		endcase
		return s;
	endfunction

endpackage

// File: hdl/avd_interfaces.sv
// ----------------------------------------------------------------------------
// avd interfaces
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface avd_in_if;
	import avd_pkg::*;
	logic                    valid;
	logic                    ready;
	logic                    command;
	logic [AVD_SAMPLE_W-1:0] sample;
	logic [AVD_MODE_W-1:0]   mode;

	modport source (output valid, output command, output sample, output mode, input ready);
	modport sink   (input valid, input command, input sample, input mode, output ready);
endinterface

interface avd_out_if;
	import avd_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [AVD_SEG_W-1:0]  segment_code;
	logic                  high_digit_on;
	logic                  display_valid;
	logic [AVD_CMP_W-1:0]  pwm_compare;
	logic [AVD_BCD_W-1:0]  voltage_bcd;
	logic                  batch_done;

	modport source (output valid, output segment_code, output high_digit_on,
		output display_valid, output pwm_compare, output voltage_bcd,
		output batch_done, input ready);
	modport sink   (input valid, input segment_code, input high_digit_on,
		input display_valid, input pwm_compare, input voltage_bcd,
		input batch_done, output ready);
endinterface

// File: hdl/avd_accum.sv
// ----------------------------------------------------------------------------
// avd_accum
// input register, batch accumulator, voltage scaling to bcd, digit select
// ----------------------------------------------------------------------------
`include "adc_voltmeter_display_dimmer_defines.svh"

module avd_accum #(
	parameter int unsigned BATCH_SAMPLES = avd_pkg::AVD_BATCH_SAMPLES
) (
	input  logic              clk,
	input  logic              arst_n,
	avd_in_if.sink            samples,
	output logic              mid_valid,
	input  logic              mid_ready,
	output avd_pkg::avd_mid_t mid
);
	import avd_pkg::*;

	localparam int unsigned SUM_W   = $clog2(BATCH_SAMPLES * AVD_SAMPLE_MAX + 1);
	localparam int unsigned CNT_W   = $clog2(BATCH_SAMPLES + 1);
	localparam int unsigned DIV     = AVD_VOLT_DIV * BATCH_SAMPLES;
	localparam int unsigned DIV_W   = $clog2(DIV + 1);
	localparam int unsigned SHIFT   = SUM_W + DIV_W;
	localparam int unsigned RECIP_W = SUM_W + 2;
	localparam int unsigned PROD_W  = SUM_W + RECIP_W;
	// ceiling reciprocal, exact for every reachable sum
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** SHIFT + DIV - 1) / DIV);

	// stage 1 input register
	logic                    v_s1;
	logic                    cmd_s1;
	logic [AVD_SAMPLE_W-1:0] sample_s1;
	logic [AVD_MODE_W-1:0]   mode_s1;

	logic                    v_s2;
	avd_mid_t                mid_s2;

	// accumulator state
	logic [SUM_W-1:0]        sum_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [AVD_BCD_W-1:0]    bcd_q;
	logic                    tog_q;

	logic                    a_ok;
	logic                    adv_a;
	logic                    tick;
	logic                    take;
	logic                    batch_end;
	logic [SUM_W-1:0]        sum_add;
	logic [CNT_W-1:0]        cnt_add;
	logic [PROD_W-1:0]       prod;
	logic [AVD_VOLT_W-1:0]   volt;
	logic [1:0]              tens;
	logic [AVD_VOLT_W-1:0]   tens10;
	logic [3:0]              ones;
	logic [AVD_BCD_W-1:0]    bcd_new;
	logic [3:0]              digit;

	assign a_ok          = !v_s2 || mid_ready;
	assign adv_a         = v_s1 && a_ok;
	assign samples.ready = !v_s1 || a_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (samples.ready) begin
			v_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			cmd_s1    <= samples.command;
			sample_s1 <= samples.sample;
			mode_s1   <= samples.mode;
		end
	end

	always_comb begin
		tick      = (cmd_s1 == AVD_CMD_TICK);
		take      = (cmd_s1 == AVD_CMD_SAMPLE) && (mode_s1 != AVD_MODE_FREEZE);
		sum_add   = sum_q + SUM_W'(sample_s1);
		cnt_add   = cnt_q + CNT_W'(1);
		batch_end = take && (cnt_add == CNT_W'(BATCH_SAMPLES));
		prod      = PROD_W'(sum_add) * PROD_W'(RECIP);
		volt      = AVD_VOLT_W'(prod >> SHIFT);
		if (volt >= 6'd30) begin
			tens = 2'd3;
		end else if (volt >= 6'd20) begin
			tens = 2'd2;
		end else if (volt >= 6'd10) begin
			tens = 2'd1;
		end else begin
			tens = 2'd0;
		end
		tens10  = AVD_VOLT_W'({tens, 3'b000}) + AVD_VOLT_W'({tens, 1'b0});
		ones    = 4'(volt - tens10);
		bcd_new = batch_end ? {tens, ones} : bcd_q;
		digit   = tog_q ? {2'b00, bcd_q[5:4]} : bcd_q[3:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			bcd_q <= '0;
			tog_q <= 1'b0;
		end else if (adv_a) begin
			if (tick) begin
				tog_q <= ~tog_q;
			end else if (batch_end) begin
				sum_q <= '0;
				cnt_q <= '0;
				bcd_q <= bcd_new;
			end else if (take) begin
				sum_q <= sum_add;
				cnt_q <= cnt_add;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (a_ok) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_a) begin
			mid_s2.seg  <= tick ? avd_seg7(digit) : '0;
			mid_s2.high <= tick && tog_q;
			mid_s2.disp <= tick;
			mid_s2.done <= batch_end;
			mid_s2.mode <= mode_s1;
			mid_s2.bcd  <= bcd_new;
		end
	end

	assign mid_valid = v_s2;
	assign mid       = mid_s2;

	`AVD_ASSERT_NOW(a_cnt_range, clk, arst_n, 1'b1, cnt_q < CNT_W'(BATCH_SAMPLES),
		"sample count reached batch size")
	`AVD_ASSERT_NOW(a_bcd_legal, clk, arst_n, 1'b1, (bcd_q[3:0] <= 4'd9) && (bcd_q <= 6'h33),
		"stored voltage is not legal bcd")
	`AVD_ASSERT_NEXT(a_batch_clear, clk, arst_n, adv_a && batch_end,
		(sum_q == '0) && (cnt_q == '0), "batch end did not clear accumulator")
	`AVD_ASSERT_NEXT(a_tick_toggle, clk, arst_n, adv_a && tick, tog_q != $past(tog_q),
		"display tick did not alternate digit")

endmodule

// File: hdl/avd_pwm.sv
// ----------------------------------------------------------------------------
// avd_pwm
// period register, duty select, compare multiply and divide by 100, output reg
// ----------------------------------------------------------------------------
`include "adc_voltmeter_display_dimmer_defines.svh"

module avd_pwm (
	input  logic              clk,
	input  logic              arst_n,
	input  avd_pkg::avd_cfg_t cfg,
	input  logic              mid_valid,
	output logic              mid_ready,
	input  avd_pkg::avd_mid_t mid,
	avd_out_if.source         results
);
	import avd_pkg::*;

	localparam int unsigned PROD_W  = AVD_CMP_W + AVD_DUTY_W;
	localparam int unsigned SCALE_W = PROD_W + AVD_PCT_RECIP_W;

	logic [AVD_PERIOD_W-1:0] period_q;

	logic                    v_s3;
	logic [PROD_W-1:0]       prod_s3;
	avd_mid_t                mid_s3;

	logic                    out_v_q;
	logic [AVD_SEG_W-1:0]    seg_q;
	logic                    high_q;
	logic                    disp_q;
	logic [AVD_CMP_W-1:0]    cmp_q;
	logic [AVD_BCD_W-1:0]    bcd_q;
	logic                    done_q;

	logic                    rdy_out;
	logic [AVD_DUTY_W-1:0]   triple;
	logic [AVD_DUTY_W-1:0]   duty;
	logic [AVD_CMP_W-1:0]    span;
	logic [SCALE_W-1:0]      scaled;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= AVD_PERIOD_RESET;
		end else if (cfg.we) begin
			period_q <= cfg.data;
		end
	end

	// 6-bit bcd value read as binary, times three
	always_comb begin
		triple = AVD_DUTY_W'({mid.bcd, 1'b0}) + AVD_DUTY_W'(mid.bcd);
		case (mid.mode)
			AVD_MODE_OFF:    duty = '0;
			AVD_MODE_FREEZE: duty = AVD_DUTY_W'(AVD_DUTY_FULL);
			default:         duty = triple;
		endcase
		if (duty > AVD_DUTY_W'(AVD_DUTY_FULL)) begin
			duty = AVD_DUTY_W'(AVD_DUTY_FALLBACK);
		end
		span   = AVD_CMP_W'(period_q) + AVD_CMP_W'(1);
		scaled = SCALE_W'(prod_s3) * SCALE_W'(AVD_PCT_RECIP);
	end

	assign rdy_out   = !out_v_q || results.ready;
	assign mid_ready = !v_s3 || rdy_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (mid_ready) begin
				v_s3 <= mid_valid;
			end
			if (rdy_out) begin
				out_v_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mid_valid && mid_ready) begin
			prod_s3 <= PROD_W'(span) * PROD_W'(duty);
			mid_s3  <= mid;
		end
		if (v_s3 && rdy_out) begin
			seg_q  <= mid_s3.seg;
			high_q <= mid_s3.high;
			disp_q <= mid_s3.disp;
			done_q <= mid_s3.done;
			bcd_q  <= mid_s3.bcd;
			cmp_q  <= AVD_CMP_W'(scaled >> AVD_PCT_SHIFT);
		end
	end

	assign results.valid         = out_v_q;
	assign results.segment_code  = seg_q;
	assign results.high_digit_on = high_q;
	assign results.display_valid = disp_q;
	assign results.pwm_compare   = cmp_q;
	assign results.voltage_bcd   = bcd_q;
	assign results.batch_done    = done_q;

	`AVD_ASSERT_NEXT(a_s3_load, clk, arst_n, mid_valid && mid_ready, v_s3,
		"accepted item missing from compare stage")
	`AVD_ASSERT_NEXT(a_out_load, clk, arst_n, v_s3 && rdy_out, out_v_q,
		"compare stage item missing from output register")
	`AVD_ASSERT_NEXT(a_duty_cap, clk, arst_n, mid_valid && mid_ready,
		prod_s3 <= PROD_W'($past(span)) * PROD_W'(AVD_DUTY_FULL),
		"compare product above full scale")

endmodule

// File: hdl/adc_voltmeter_display_dimmer.sv
// ----------------------------------------------------------------------------
// adc_voltmeter_display_dimmer
// averaging voltmeter with two-digit 7-segment mux and pwm dimmer compare
// ----------------------------------------------------------------------------
//
// channel   dir   transfer moves
// --------  ----  ------------------------------------------------------
// samples   in    command, sample, mode (sample or display tick)
// results   out   segment_code, high_digit_on, display_valid,
//                 pwm_compare, voltage_bcd, batch_done
// cfg_wr_*  in    pwm_period write, no handshake, no read-back
//
// one transfer in and one result out per cycle while nothing stalls, through the
// input register, accumulate/scale stage, compare multiply, divide by 100
// into the output register; each stage holds its own valid bit and stalls
// only when the stage after it is full and stalled
// async active-low reset clears valid bits, the accumulator, the stored
// voltage, the digit toggle and sets pwm_period to 49999; no clearing pass
//
module adc_voltmeter_display_dimmer #(
	parameter int unsigned BATCH_SAMPLES = avd_pkg::AVD_BATCH_SAMPLES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [avd_pkg::AVD_PERIOD_W-1:0] cfg_wr_data,
	avd_in_if.sink                           samples,
	avd_out_if.source                        results
);
	import avd_pkg::*;

	// handoff between the accumulator and the pwm stages
	logic     mid_valid;
	logic     mid_ready;
	avd_mid_t mid;
	avd_cfg_t cfg;

	assign cfg.we   = cfg_wr_en;
	assign cfg.data = cfg_wr_data;

	// batch sum, average scaled to tenths of a volt, bcd store and digit pick
	avd_accum #(
		.BATCH_SAMPLES (BATCH_SAMPLES)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples),
		.mid_valid (mid_valid),
		.mid_ready (mid_ready),
		.mid       (mid)
	);

	// duty from mode and new voltage, then (period + 1) * duty / 100
	avd_pwm u_pwm (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.mid_valid (mid_valid),
		.mid_ready (mid_ready),
		.mid       (mid),
		.results   (results)
	);

endmodule

// File: bench/avd_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avd result checker
// watches both channels and the period write port, keeps its own copy of the
// meter state, predicts every result in order and compares it field by field
// ----------------------------------------------------------------------------
module avd_result_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [avd_pkg::AVD_PERIOD_W-1:0] cfg_wr_data,
	avd_in_if                                samples,
	avd_out_if                               results,
	output int unsigned                      pending,
	output int unsigned                      failures
);
	import avd_pkg::*;

	localparam int unsigned FULL_SCALE_TENTHS = 33;

	typedef struct packed {
		logic [AVD_SEG_W-1:0] seg;
		logic                 high;
		logic                 disp;
		logic [AVD_CMP_W-1:0] cmp;
		logic [AVD_BCD_W-1:0] bcd;
		logic                 done;
	} reading_t;

	// segment patterns, digits 0..f
	logic [AVD_SEG_W-1:0] digit_segments [0:15] = '{
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
		7'h7F, 7'h6F, 7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71
	};

	reading_t                readings_due [$];
	logic [AVD_PERIOD_W-1:0] period_reg;
	logic [12:0]             batch_sum;
	logic [3:0]              batch_count;
	logic [7:0]              volt_bcd;
	logic                    show_high;
	int unsigned             readings_seen;

	task automatic report_mismatch(input string what);
		failures++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	function automatic logic [AVD_CMP_W-1:0] pwm_compare_for(input logic [AVD_MODE_W-1:0] md);
		int unsigned duty;
		if (md == AVD_MODE_OFF)
			duty = 0;
		else if (md == AVD_MODE_FREEZE)
			duty = AVD_DUTY_FULL;
		else
			duty = int'(volt_bcd) * 3;
		if (duty > AVD_DUTY_FULL)
			duty = AVD_DUTY_FALLBACK;
		return AVD_CMP_W'((int'(period_reg) + 1) * duty / AVD_PCT);
	endfunction

	// advances the meter state by one transfer and returns what it must produce
	function automatic reading_t predict_reading(input logic cmd,
		input logic [AVD_SAMPLE_W-1:0] value, input logic [AVD_MODE_W-1:0] md);
		reading_t    r;
		int unsigned tenths;
		r = '0;
		if (cmd == AVD_CMD_TICK) begin
			r.high = show_high;
			r.seg = digit_segments[show_high ? volt_bcd[7:4] : volt_bcd[3:0]];
			r.disp = 1'b1;
			show_high = !show_high;
		end else if (md != AVD_MODE_FREEZE) begin
			batch_sum = batch_sum + 13'(value);
			batch_count = batch_count + 4'd1;
			if (batch_count >= AVD_BATCH_SAMPLES) begin
				tenths = (int'(batch_sum) / AVD_BATCH_SAMPLES) * FULL_SCALE_TENTHS
					/ AVD_SAMPLE_MAX;
				volt_bcd = 8'(((tenths / 10) << 4) + tenths % 10);
				batch_sum = '0;
				batch_count = '0;
				r.done = 1'b1;
			end
		end
		r.cmp = pwm_compare_for(md);
		r.bcd = volt_bcd[AVD_BCD_W-1:0];
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s: expected %0h, got %0h",
				readings_seen, name, want, got));
	endtask

	task automatic check_reading();
		reading_t want;
		readings_seen++;
		if (readings_due.size() == 0) begin
			report_mismatch($sformatf("result %0d arrived with nothing outstanding",
				readings_seen));
			return;
		end
		want = readings_due.pop_front();
		check_field("segment_code", want.seg, results.segment_code);
		check_field("high_digit_on", want.high, results.high_digit_on);
		check_field("display_valid", want.disp, results.display_valid);
		check_field("pwm_compare", want.cmp, results.pwm_compare);
		check_field("voltage_bcd", want.bcd, results.voltage_bcd);
		check_field("batch_done", want.done, results.batch_done);
	endtask

	// inputs settle before the edge, so values read here are the ones transferred
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			readings_due.delete();
			period_reg = AVD_PERIOD_RESET;
			batch_sum = '0;
			batch_count = '0;
			volt_bcd = '0;
			show_high = 1'b0;
			readings_seen = 0;
			failures = 0;
			pending = 0;
		end else begin
			if (cfg_wr_en)
				period_reg = cfg_wr_data;
			if (samples.valid && samples.ready)
				readings_due.push_back(predict_reading(samples.command,
					samples.sample, samples.mode));
			if (results.valid && results.ready)
				check_reading();
			pending = readings_due.size();
		end
	end

endmodule

// File: bench/adc_voltmeter_display_dimmer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_voltmeter_display_dimmer_tb
// drives sample and tick transfers with random gaps and result stalls, moves
// the pwm period through its extremes between phases, and lets the checker
// beside the block predict and compare every result
// ----------------------------------------------------------------------------
module adc_voltmeter_display_dimmer_tb;
	import avd_pkg::*;

	// the two dimmer switch positions have no name in the package
	localparam logic [AVD_MODE_W-1:0] MODE_DIM     = 2'd2;
	localparam logic [AVD_MODE_W-1:0] MODE_DIM_ALT = 2'd3;

	// four pipeline stages plus margin
	localparam int unsigned DRAIN_CYCLES   = 12;
	localparam int unsigned PHASE_ITEMS    = 97;
	localparam int unsigned PHASE_COUNT    = 7;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_wr_en;
	logic [AVD_PERIOD_W-1:0] cfg_wr_data;
	int unsigned             pending;
	int unsigned             failures;

	// calm phases run with no gaps and no stalls at all
	bit          calm;
	// slowly moving converter level so that batches land on every voltage
	int unsigned level;

	avd_in_if  samples ();
	avd_out_if results ();

	adc_voltmeter_display_dimmer uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.samples     (samples),
		.results     (results)
	);

	avd_result_checker result_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.samples     (samples),
		.results     (results),
		.pending     (pending),
		.failures    (failures)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// generous ceiling, far above the slowest correct run
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// one transfer on the sample channel: random gap first outside calm phases, then hold valid
	// until the block takes it; ready is stable by the falling edge
	task automatic send_item(input logic cmd, input logic [AVD_SAMPLE_W-1:0] value,
		input logic [AVD_MODE_W-1:0] md);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			samples.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samples.valid <= 1'b1;
		samples.command <= cmd;
		samples.sample <= value;
		samples.mode <= md;
		do @(negedge clk); while (!samples.ready);
		@(posedge clk);
	endtask

	// mostly samples near the current level, some extremes and wild values,
	// ticks mixed in, every switch position including freeze
	task automatic send_random_item();
		logic                  cmd;
		logic [AVD_MODE_W-1:0] md;
		int                    value;
		if ($urandom_range(0, 15) == 0)
			level = $urandom_range(0, AVD_SAMPLE_MAX);
		cmd = ($urandom_range(0, 9) < 4) ? AVD_CMD_TICK : AVD_CMD_SAMPLE;
		md = AVD_MODE_W'($urandom_range(0, 3));
		case ($urandom_range(0, 9))
			0: value = 0;
			1: value = AVD_SAMPLE_MAX;
			2: value = $urandom_range(0, AVD_SAMPLE_MAX);
			default: value = int'(level) + int'($urandom_range(0, 31)) - 16;
		endcase
		if (value < 0)
			value = 0;
		if (value > int'(AVD_SAMPLE_MAX))
			value = AVD_SAMPLE_MAX;
		send_item(cmd, AVD_SAMPLE_W'(value), md);
	endtask

	// drain everything, let the pipeline empty, then write the period
	task automatic set_period(input logic [AVD_PERIOD_W-1:0] value);
		samples.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// result side: a random stall before each result outside calm phases, then ready until a transfer
	initial begin
		int unsigned stall;
		results.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 3);
			if (stall != 0) begin
				results.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			results.ready <= 1'b1;
			do @(negedge clk); while (!results.valid);
			@(posedge clk);
		end
	end

	initial begin
		logic [AVD_MODE_W-1:0]   batch_modes [0:2] = '{AVD_MODE_OFF, MODE_DIM, MODE_DIM_ALT};
		logic [AVD_PERIOD_W-1:0] phase_periods [0:PHASE_COUNT-1];
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		samples.valid <= 1'b0;
		samples.command <= AVD_CMD_SAMPLE;
		samples.sample <= '0;
		samples.mode <= AVD_MODE_OFF;
		calm = 1'b0;
		level = AVD_SAMPLE_MAX / 2;
		// zero, largest period (period + 1 needs 17 bits), tiny, exact hundred, reset value, random
		phase_periods = '{16'd0, 16'hFFFF, 16'd1, 16'd99, AVD_PERIOD_RESET,
			AVD_PERIOD_W'($urandom), AVD_PERIOD_W'($urandom)};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, at the reset period
		// ticks right after reset: low digit first, zero shown, in off and freeze modes
		send_item(AVD_CMD_TICK, '0, AVD_MODE_OFF);
		send_item(AVD_CMD_TICK, 10'h3FF, AVD_MODE_FREEZE);
		// a sample while frozen is dropped
		send_item(AVD_CMD_SAMPLE, 10'h3FF, AVD_MODE_FREEZE);
		// full-scale batch: 3.3 V, dimmer duty overflows to the fallback
		for (int i = 0; i < int'(AVD_BATCH_SAMPLES); i++)
			send_item(AVD_CMD_SAMPLE, 10'h3FF, batch_modes[i % 3]);
		send_item(AVD_CMD_TICK, '0, MODE_DIM);
		send_item(AVD_CMD_TICK, '0, MODE_DIM_ALT);
		// zero batch brings the stored voltage back down
		for (int i = 0; i < int'(AVD_BATCH_SAMPLES); i++)
			send_item(AVD_CMD_SAMPLE, '0, MODE_DIM);
		send_item(AVD_CMD_TICK, 10'h155, MODE_DIM_ALT);
		send_item(AVD_CMD_TICK, 10'h2AA, AVD_MODE_FREEZE);

		// random part, one period setting per phase, every third phase calm
		for (int p = 0; p < int'(PHASE_COUNT); p++) begin
			set_period(phase_periods[p]);
			calm = (p % 3 == 2);
			for (int i = 0; i < int'(PHASE_ITEMS); i++)
				send_random_item();
		end

		samples.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
